>>> sv/cal2ep_pkg.sv
// ----------------------------------------------------------------------------
// cal2ep_pkg
// Shared types, constants and calendar tables for the date to epoch converter.
// ----------------------------------------------------------------------------
package cal2ep_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int USEC_W  = 20;
  localparam int EPOCH_W = 39;
  localparam int TOD_W   = 17;
  localparam int DAYS_W  = 24;
  localparam int WIDE_W  = 41;

  localparam int EPOCH_YEAR    = 1970;
  localparam int DAYS_PER_YEAR = 365;
  localparam int LEAP_OFFSET   = 477;
  localparam int SECS_PER_DAY  = 86400;
  localparam int SECS_PER_HOUR = 3600;
  localparam int SECS_PER_MIN  = 60;
  localparam int HOURS_PER_DAY = 24;
  localparam int MINS_PER_HOUR = 60;
  localparam int SECS_PER_MINUTE_MAX = 60;

  // floor(x / 100) == (x * 5243) >> 19 for every 14-bit x
  localparam logic [12:0] RECIP_100 = 13'd5243;
  localparam int RECIP_SHIFT = 19;
  localparam int PROD_W = YEAR_W + 13;
  localparam int QUOT_W = PROD_W - RECIP_SHIFT;

  localparam logic signed [WIDE_W-1:0] EPOCH_MAX = 41'sd274877906943;

  typedef logic signed [DAYS_W-1:0] days_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  typedef enum logic [2:0] {
    STATUS_OK      = 3'd0,
    STATUS_BAD_MON = 3'd1,
    STATUS_BAD_DAY = 3'd2,
    STATUS_BAD_HR  = 3'd3,
    STATUS_BAD_MIN = 3'd4,
    STATUS_BAD_SEC = 3'd5
  } status_t;

  typedef struct packed {
    days_t              days;
    logic [TOD_W-1:0]   tod;
    logic [USEC_W-1:0]  usec;
    status_t            status;
  } day_beat_t;

  localparam logic [8:0] START_COMMON [16] = '{
    9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd0, 9'd0, 9'd0
  };
  localparam logic [8:0] START_LEAP [16] = '{
    9'd0, 9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
    9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd0, 9'd0, 9'd0
  };
  localparam logic [4:0] LEN_COMMON [16] = '{
    5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
  };
  localparam logic [4:0] LEN_LEAP [16] = '{
    5'd0, 5'd31, 5'd29, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
  };

  function automatic logic [8:0] month_start(input logic leap, input logic [MONTH_W-1:0] m);
    month_start = leap ? START_LEAP[m] : START_COMMON[m];
  endfunction

  function automatic logic [4:0] month_len(input logic leap, input logic [MONTH_W-1:0] m);
    month_len = leap ? LEN_LEAP[m] : LEN_COMMON[m];
  endfunction

endpackage

>>> sv/cal2ep_if.sv
// ----------------------------------------------------------------------------
// cal2ep_if
// Valid/ready channels for calendar date beats and epoch result beats.
// ----------------------------------------------------------------------------
interface cal2ep_date_if;
  logic        valid;
  logic        ready;
  logic [13:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic [19:0] microseconds_in;

  modport source (
    output valid, year, month, day, hour, minute, second, microseconds_in,
    input  ready
  );
  modport sink (
    input  valid, year, month, day, hour, minute, second, microseconds_in,
    output ready
  );
endinterface

interface cal2ep_epoch_if;
  logic              valid;
  logic              ready;
  logic signed [38:0] epoch_seconds;
  logic [19:0]       microseconds_out;
  logic [2:0]        status;

  modport source (output valid, epoch_seconds, microseconds_out, status, input ready);
  modport sink   (input valid, epoch_seconds, microseconds_out, status, output ready);
endinterface

>>> sv/calendar_to_epoch_seconds_top.sv
// ----------------------------------------------------------------------------
// calendar_to_epoch_seconds_top
// Converts a UTC calendar date and time to signed seconds since 1970-01-01.
//
// The date channel takes one beat of year, month, day, hour, minute, second
// and microseconds; the epoch channel returns one beat per date beat, in
// order, with the seconds, the microseconds copied through and a status code
// naming the first bad field (month, day, hour, minute, second). On a bad
// field the seconds hold the sum of the fields checked before it.
// Seconds above 2^38-1 saturate there.
// One beat is taken every cycle while the receiver keeps epoch.ready high;
// the block has five register stages, the last of which is the output
// register. Each stage holds its beat while the one after it is full, so a
// stalled receiver fills the pipeline before date.ready drops, and bubbles
// are squeezed out. Nothing is lost or repeated.
// Reset clears the stage valid bits only; the block keeps no other state.
// ----------------------------------------------------------------------------
module calendar_to_epoch_seconds_top (
  input  logic            clk,
  input  logic            rst,
  cal2ep_date_if.sink     date,
  cal2ep_epoch_if.source  epoch
);
  import cal2ep_pkg::*;

  logic      beat_valid;
  logic      beat_ready;
  day_beat_t beat;

  cal2ep_days u_days (
    .clk        (clk),
    .rst        (rst),
    .date       (date),
    .beat_valid (beat_valid),
    .beat_ready (beat_ready),
    .beat       (beat)
  );

  cal2ep_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .beat_valid (beat_valid),
    .beat_ready (beat_ready),
    .beat       (beat),
    .epoch      (epoch)
  );

endmodule

>>> sv/cal2ep_days.sv
// ----------------------------------------------------------------------------
// cal2ep_days
// Three stage front end: year reciprocals, leap rule and day count, then field
// checks, status and time of day.
// ----------------------------------------------------------------------------
module cal2ep_days (
  input  logic                  clk,
  input  logic                  rst,
  cal2ep_date_if.sink           date,
  output logic                  beat_valid,
  input  logic                  beat_ready,
  output cal2ep_pkg::day_beat_t beat
);
  import cal2ep_pkg::*;

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;

  // stage 1 registers
  logic [YEAR_W-1:0]  s1_year;
  logic               s1_year_zero;
  logic [YEAR_W-1:0]  s1_prev;
  logic [PROD_W-1:0]  s1_yq;
  logic [PROD_W-1:0]  s1_pq;
  days_t              s1_yr365;
  logic [MONTH_W-1:0] s1_month;
  logic [DAY_W-1:0]   s1_day;
  logic [HOUR_W-1:0]  s1_hour;
  logic [MIN_W-1:0]   s1_minute;
  logic [SEC_W-1:0]   s1_second;
  logic [USEC_W-1:0]  s1_usec;

  // stage 2 registers
  logic               s2_leap;
  days_t              s2_base;
  logic [MONTH_W-1:0] s2_month;
  logic [DAY_W-1:0]   s2_day;
  logic [HOUR_W-1:0]  s2_hour;
  logic [MIN_W-1:0]   s2_minute;
  logic [SEC_W-1:0]   s2_second;
  logic [USEC_W-1:0]  s2_usec;

  // stage 1 logic
  logic signed [YEAR_W:0] ydiff;
  logic [YEAR_W-1:0]      prev;

  // stage 2 logic
  logic [QUOT_W-1:0]  yq_q;
  logic [QUOT_W-1:0]  pq_q;
  logic [YEAR_W-1:0]  yrem;
  logic               leap;
  logic [11:0]        leaps_pos;
  logic signed [12:0] leaps;

  // stage 3 logic
  logic               m_ok, d_ok, h_ok, mi_ok, s_ok;
  logic [4:0]         mlen;
  days_t              days_next;
  logic [TOD_W-1:0]   tod_next;
  status_t            status_next;

  assign rdy3       = !v3 || beat_ready;
  assign rdy2       = !v2 || rdy3;
  assign rdy1       = !v1 || rdy2;
  assign date.ready = rdy1;
  assign beat_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= date.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  assign ydiff = $signed({1'b0, date.year}) - (YEAR_W+1)'(EPOCH_YEAR);
  assign prev  = date.year - YEAR_W'(1);

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_year      <= date.year;
      s1_year_zero <= (date.year == '0);
      s1_prev      <= prev;
      s1_yq        <= PROD_W'(date.year) * PROD_W'(RECIP_100);
      s1_pq        <= PROD_W'(prev) * PROD_W'(RECIP_100);
      s1_yr365     <= days_t'(ydiff) * days_t'(DAYS_PER_YEAR);
      s1_month     <= date.month;
      s1_day       <= date.day;
      s1_hour      <= date.hour;
      s1_minute    <= date.minute;
      s1_second    <= date.second;
      s1_usec      <= date.microseconds_in;
    end
  end

  // leap rule and leap days before the year
  always_comb begin
    yq_q      = s1_yq[PROD_W-1:RECIP_SHIFT];
    pq_q      = s1_pq[PROD_W-1:RECIP_SHIFT];
    yrem      = s1_year - YEAR_W'(yq_q) * YEAR_W'(100);
    leap      = (s1_year[1:0] == 2'b00) && ((yrem != '0) || (yq_q[1:0] == 2'b00));
    leaps_pos = 12'(s1_prev[YEAR_W-1:2]) - 12'(pq_q) + 12'(pq_q[QUOT_W-1:2]);
    leaps     = s1_year_zero ? -13'sd1 : $signed({1'b0, leaps_pos});
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_leap   <= leap;
      s2_base   <= s1_yr365 + days_t'(leaps) - days_t'(LEAP_OFFSET);
      s2_month  <= s1_month;
      s2_day    <= s1_day;
      s2_hour   <= s1_hour;
      s2_minute <= s1_minute;
      s2_second <= s1_second;
      s2_usec   <= s1_usec;
    end
  end

  // field checks in order, partial sums up to the first bad field
  always_comb begin
    mlen  = month_len(s2_leap, s2_month);
    m_ok  = (s2_month != '0) && (s2_month <= MONTH_W'(12));
    d_ok  = m_ok && (s2_day != '0) && (s2_day <= mlen);
    h_ok  = d_ok && (s2_hour < HOUR_W'(HOURS_PER_DAY));
    mi_ok = h_ok && (s2_minute < MIN_W'(MINS_PER_HOUR));
    s_ok  = mi_ok && (s2_second < SEC_W'(SECS_PER_MINUTE_MAX));

    days_next = s2_base
              + (m_ok ? days_t'(month_start(s2_leap, s2_month)) : days_t'(0))
              + (d_ok ? days_t'(s2_day - DAY_W'(1)) : days_t'(0));
    tod_next  = (h_ok  ? TOD_W'(s2_hour) * TOD_W'(SECS_PER_HOUR) : '0)
              + (mi_ok ? TOD_W'(s2_minute) * TOD_W'(SECS_PER_MIN) : '0)
              + (s_ok  ? TOD_W'(s2_second) : '0);

    priority if (!m_ok) status_next = STATUS_BAD_MON;
    else if (!d_ok)     status_next = STATUS_BAD_DAY;
    else if (!h_ok)     status_next = STATUS_BAD_HR;
    else if (!mi_ok)    status_next = STATUS_BAD_MIN;
    else if (!s_ok)     status_next = STATUS_BAD_SEC;
    else                status_next = STATUS_OK;
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      beat.days   <= days_next;
      beat.tod    <= tod_next;
      beat.usec   <= s2_usec;
      beat.status <= status_next;
    end
  end

endmodule

>>> sv/cal2ep_scale.sv
// ----------------------------------------------------------------------------
// cal2ep_scale
// Back end: day count times seconds per day, then time of day added,
// saturation and the output register.
// ----------------------------------------------------------------------------
module cal2ep_scale (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  beat_valid,
  output logic                  beat_ready,
  input  cal2ep_pkg::day_beat_t beat,
  cal2ep_epoch_if.source        epoch
);
  import cal2ep_pkg::*;

  logic v4, v5;
  logic rdy4, rdy5;

  wide_t              s4_prod;
  logic [TOD_W-1:0]   s4_tod;
  logic [USEC_W-1:0]  s4_usec;
  status_t            s4_status;

  wide_t              sum;

  logic signed [EPOCH_W-1:0] epoch_seconds;
  logic [USEC_W-1:0]         usec;
  status_t                   status;

  assign rdy5        = !v5 || epoch.ready;
  assign rdy4        = !v4 || rdy5;
  assign beat_ready  = rdy4;
  assign epoch.valid = v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy4) v4 <= beat_valid;
      if (rdy5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_prod   <= wide_t'(beat.days) * wide_t'(SECS_PER_DAY);
      s4_tod    <= beat.tod;
      s4_usec   <= beat.usec;
      s4_status <= beat.status;
    end
  end

  assign sum = s4_prod + $signed({(WIDE_W-TOD_W)'(0), s4_tod});

  always_ff @(posedge clk) begin
    if (rdy5) begin
      epoch_seconds <= (sum > EPOCH_MAX) ? EPOCH_MAX[EPOCH_W-1:0] : sum[EPOCH_W-1:0];
      usec          <= s4_usec;
      status        <= s4_status;
    end
  end

  assign epoch.epoch_seconds    = epoch_seconds;
  assign epoch.microseconds_out = usec;
  assign epoch.status           = status;

endmodule

>>> tb/tb_calendar_to_epoch_seconds_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_calendar_to_epoch_seconds_top
// Drives calendar date beats into the converter and checks every epoch beat
// against an in-order predictor of the seconds, the microseconds and the
// status. A directed set covers the field extremes, leap years, year zero,
// saturation and each bad field. Random beats follow, mostly well-formed
// dates with bad fields now and then. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_calendar_to_epoch_seconds_top;
  import cal2ep_pkg::*;

  localparam int N_RANDOM   = 450;
  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN_WAIT = 10;

  typedef struct {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;
    logic [USEC_W-1:0]  usec;
    int unsigned        gap;
    bit                 drain_first;
  } date_item_t;

  typedef struct {
    logic signed [EPOCH_W-1:0] secs;
    logic [USEC_W-1:0]         usec;
    status_t                   status;
  } epoch_item_t;

  logic clk;
  logic rst;

  cal2ep_date_if  date_ch ();
  cal2ep_epoch_if epoch_ch ();

  calendar_to_epoch_seconds_top dut (
    .clk   (clk),
    .rst   (rst),
    .date  (date_ch),
    .epoch (epoch_ch)
  );

  date_item_t  dates_to_send [$];
  epoch_item_t epochs_due [$];
  int          dates_left;
  int          mismatches;
  int          results_seen;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned idle_cycles;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic bit is_leap_year(input longint y);
    if (y % 4 != 0) return 1'b0;
    if (y % 100 != 0) return 1'b1;
    return (y % 400) == 0;
  endfunction

  function automatic int days_in_month(input bit leap, input int m);
    case (m)
      2: return leap ? 29 : 28;
      4, 6, 9, 11: return 30;
      default: return 31;
    endcase
  endfunction

  function automatic epoch_item_t epoch_of_date(input date_item_t d);
    longint      y;
    longint      leaps;
    longint      secs;
    longint      mdays;
    bit          leap;
    int          mon;
    int          mlen;
    epoch_item_t r;
    y = d.year;
    if (y >= 1) leaps = (y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400;
    else leaps = -1;
    secs = ((y - 1970) * 365 + leaps - 477) * 86400;
    r.status = STATUS_OK;
    if (d.month == 0 || d.month > 12) begin
      r.status = STATUS_BAD_MON;
    end else begin
      leap = is_leap_year(y);
      mdays = 0;
      for (mon = 1; mon < int'(d.month); mon++) mdays += days_in_month(leap, mon);
      secs += mdays * 86400;
      mlen = days_in_month(leap, d.month);
      if (d.day == 0 || int'(d.day) > mlen) begin
        r.status = STATUS_BAD_DAY;
      end else begin
        secs += (longint'(d.day) - 1) * 86400;
        if (d.hour > 23) begin
          r.status = STATUS_BAD_HR;
        end else begin
          secs += longint'(d.hour) * 3600;
          if (d.minute > 59) begin
            r.status = STATUS_BAD_MIN;
          end else begin
            secs += longint'(d.minute) * 60;
            if (d.second > 59) r.status = STATUS_BAD_SEC;
            else secs += d.second;
          end
        end
      end
    end
    if (secs > 64'sd274877906943) secs = 64'sd274877906943;
    r.secs = secs[EPOCH_W-1:0];
    r.usec = d.usec;
    return r;
  endfunction

  function automatic date_item_t make_date(input int y, input int mo, input int d,
                                           input int h, input int mi, input int s,
                                           input int us);
    date_item_t it;
    it.year = YEAR_W'(y);
    it.month = MONTH_W'(mo);
    it.day = DAY_W'(d);
    it.hour = HOUR_W'(h);
    it.minute = MIN_W'(mi);
    it.second = SEC_W'(s);
    it.usec = USEC_W'(us);
    it.gap = 0;
    it.drain_first = 1'b0;
    return it;
  endfunction

  function automatic date_item_t random_date(input int idx);
    date_item_t it;
    int         r;
    int         mlen;
    r = $urandom_range(0, 99);
    if (r < 75) it.year = YEAR_W'($urandom_range(1, 9999));
    else if (r < 90) it.year = YEAR_W'($urandom_range(0, 16383));
    else it.year = YEAR_W'($urandom_range(10600, 10760));
    it.month = MONTH_W'($urandom_range(1, 12));
    mlen = days_in_month(is_leap_year(it.year), it.month);
    it.day = DAY_W'($urandom_range(1, mlen));
    it.hour = HOUR_W'($urandom_range(0, 23));
    it.minute = MIN_W'($urandom_range(0, 59));
    it.second = SEC_W'($urandom_range(0, 59));
    if ($urandom_range(0, 9) == 0) it.usec = USEC_W'($urandom_range(0, 20'hFFFFF));
    else it.usec = USEC_W'($urandom_range(0, 999999));
    if ($urandom_range(0, 99) >= 75) begin
      case ($urandom_range(0, 5))
        0: it.month = ($urandom_range(0, 3) == 0) ? MONTH_W'(0)
                      : MONTH_W'($urandom_range(13, 15));
        1: it.day = (mlen == 31 || $urandom_range(0, 2) == 0) ? DAY_W'(0)
                    : DAY_W'($urandom_range(mlen + 1, 31));
        2: it.hour = HOUR_W'($urandom_range(24, 31));
        3: it.minute = MIN_W'($urandom_range(60, 63));
        4: it.second = SEC_W'($urandom_range(60, 63));
        default: begin
          it.month = MONTH_W'($urandom_range(0, 15));
          it.day = DAY_W'($urandom_range(0, 31));
          it.hour = HOUR_W'($urandom_range(0, 31));
          it.minute = MIN_W'($urandom_range(0, 63));
          it.second = SEC_W'($urandom_range(0, 63));
        end
      endcase
    end
    r = $urandom_range(0, 99);
    case ((idx / 40) % 3)
      0: it.gap = 0;
      1: it.gap = (r < 70) ? 0 : $urandom_range(1, 3);
      default: it.gap = (r < 50) ? 0 : (r < 85) ? $urandom_range(1, 4)
                        : $urandom_range(10, 40);
    endcase
    it.drain_first = (idx == 150 || idx == 300);
    return it;
  endfunction

  function automatic int unsigned pick_stall(input int seen);
    int r;
    r = $urandom_range(0, 99);
    case ((seen / 50) % 3)
      0: return 0;
      1: return (r < 25) ? $urandom_range(1, 3) : 0;
      default: begin
        if (r >= 15) return 0;
        return ($urandom_range(0, 9) < 7) ? $urandom_range(1, 4) : $urandom_range(10, 50);
      end
    endcase
  endfunction

  // sender side
  always @(posedge clk) begin : date_driver
    date_item_t sent;
    date_item_t nxt;
    if (rst) begin
      date_ch.valid <= 1'b0;
      date_ch.year <= '0;
      date_ch.month <= '0;
      date_ch.day <= '0;
      date_ch.hour <= '0;
      date_ch.minute <= '0;
      date_ch.second <= '0;
      date_ch.microseconds_in <= '0;
      gap_left <= 0;
    end else begin
      if (date_ch.valid && date_ch.ready) begin
        sent = make_date(date_ch.year, date_ch.month, date_ch.day, date_ch.hour,
                         date_ch.minute, date_ch.second, date_ch.microseconds_in);
        epochs_due.push_back(epoch_of_date(sent));
        dates_left--;
      end
      if (!date_ch.valid || date_ch.ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          date_ch.valid <= 1'b0;
        end else if (dates_to_send.size() != 0 &&
                     !(dates_to_send[0].drain_first && epochs_due.size() != 0)) begin
          nxt = dates_to_send.pop_front();
          date_ch.valid <= 1'b1;
          date_ch.year <= nxt.year;
          date_ch.month <= nxt.month;
          date_ch.day <= nxt.day;
          date_ch.hour <= nxt.hour;
          date_ch.minute <= nxt.minute;
          date_ch.second <= nxt.second;
          date_ch.microseconds_in <= nxt.usec;
          gap_left <= nxt.gap;
        end else begin
          date_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver side
  always @(posedge clk) begin : epoch_monitor
    epoch_item_t want;
    if (rst) begin
      epoch_ch.ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (epoch_ch.valid && epoch_ch.ready) begin
        results_seen++;
        if (epochs_due.size() == 0) begin
          $error("epoch beat with no date beat outstanding");
          mismatches++;
        end else begin
          want = epochs_due.pop_front();
          if (epoch_ch.epoch_seconds !== want.secs) begin
            $error("epoch_seconds: expected %0d, got %0d", want.secs,
                   epoch_ch.epoch_seconds);
            mismatches++;
          end
          if (epoch_ch.microseconds_out !== want.usec) begin
            $error("microseconds_out: expected %0d, got %0d", want.usec,
                   epoch_ch.microseconds_out);
            mismatches++;
          end
          if (epoch_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, epoch_ch.status);
            mismatches++;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        epoch_ch.ready <= 1'b0;
      end else begin
        epoch_ch.ready <= 1'b1;
        stall_left <= pick_stall(results_seen);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((date_ch.valid && date_ch.ready) || (epoch_ch.valid && epoch_ch.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

  initial begin
    rst <= 1'b1;
    mismatches = 0;
    results_seen = 0;

    // epoch origin, one second before it, year zero, year one and 9999-12-31
    dates_to_send.push_back(make_date(1970, 1, 1, 0, 0, 0, 0));
    dates_to_send.push_back(make_date(1969, 12, 31, 23, 59, 59, 999999));
    dates_to_send.push_back(make_date(0, 1, 1, 0, 0, 0, 0));
    dates_to_send.push_back(make_date(0, 2, 29, 12, 0, 0, 5));
    dates_to_send.push_back(make_date(1, 1, 1, 0, 0, 0, 0));
    dates_to_send.push_back(make_date(9999, 12, 31, 23, 59, 59, 999999));
    // leap rule: every fourth, not centuries, but every fourth century
    dates_to_send.push_back(make_date(2000, 2, 29, 6, 30, 15, 1));
    dates_to_send.push_back(make_date(1900, 2, 29, 0, 0, 0, 0));
    dates_to_send.push_back(make_date(2100, 2, 28, 23, 59, 59, 0));
    dates_to_send.push_back(make_date(2400, 2, 29, 1, 2, 3, 4));
    dates_to_send.push_back(make_date(2023, 2, 29, 0, 0, 0, 0));
    // bad month
    dates_to_send.push_back(make_date(2024, 0, 10, 0, 0, 0, 0));
    dates_to_send.push_back(make_date(2024, 13, 10, 0, 0, 0, 0));
    dates_to_send.push_back(make_date(16383, 15, 31, 31, 63, 63, 20'hFFFFF));
    // saturation
    dates_to_send.push_back(make_date(16383, 12, 31, 23, 59, 59, 0));
    dates_to_send.push_back(make_date(10680, 12, 31, 23, 59, 59, 0));
    dates_to_send.push_back(make_date(10681, 1, 1, 0, 0, 0, 0));
    // bad day, hour, minute, second
    dates_to_send.push_back(make_date(2024, 4, 31, 0, 0, 0, 0));
    dates_to_send.push_back(make_date(2024, 7, 0, 0, 0, 0, 0));
    dates_to_send.push_back(make_date(2024, 6, 15, 24, 0, 0, 0));
    dates_to_send.push_back(make_date(2024, 6, 15, 31, 0, 0, 0));
    dates_to_send.push_back(make_date(2024, 6, 15, 23, 60, 0, 0));
    dates_to_send.push_back(make_date(2024, 6, 15, 23, 63, 0, 0));
    dates_to_send.push_back(make_date(2024, 6, 15, 23, 59, 60, 0));
    dates_to_send.push_back(make_date(2024, 6, 15, 23, 59, 63, 0));
    // microseconds beyond a second, and all zero
    dates_to_send.push_back(make_date(2024, 12, 1, 0, 0, 0, 1000000));
    dates_to_send.push_back(make_date(0, 0, 0, 0, 0, 0, 0));

    for (int i = 0; i < N_RANDOM; i++) dates_to_send.push_back(random_date(i));
    dates_left = dates_to_send.size();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (dates_left != 0 || epochs_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
